// ===== sv/block_buffer_cache_lookup_assert.svh =====
// Assertion macros shared by the buffer cache lookup RTL.
`ifndef BLOCK_BUFFER_CACHE_LOOKUP_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LOOKUP_ASSERT_SVH
`ifndef SYNTH
// General property, sampled on clk and switched off while rst_n is low.
`define BBCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication between a condition and its consequence.
`define BBCL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BBCL_ASSERT(lbl, prop, msg)
`define BBCL_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/bbcl_pkg.sv =====
// Types and constants shared by the buffer cache lookup modules.
`timescale 1ns / 1ps
package bbcl_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_DIRTY = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] device;
        logic [7:0] block;
        logic [7:0] count;
    } entry_t;

    typedef struct packed {
        logic       tag_match;
        logic       count_zero;
        logic [7:0] count_eff;
        logic [7:0] count_inc;
    } cmp_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HSCAN,
        ST_FSCAN,
        ST_DREAD,
        ST_DIRECT,
        ST_WAIT
    } state_t;

endpackage

// ===== sv/bbcl_table.sv =====
// Entry memory holding tags and reference counts, one write and one read port.
`timescale 1ns / 1ps
module bbcl_table
    import bbcl_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bbcl_cmp.sv =====
// Shared compare and count unit used by every scan and update step.
`timescale 1ns / 1ps
module bbcl_cmp
    import bbcl_pkg::*;
(
    input  entry_t     ent,
    input  logic       ent_assigned,
    input  logic [7:0] req_device,
    input  logic [7:0] req_block,
    output cmp_res_t   res
);

    // An entry that was never assigned never matches a tag and counts as zero, whatever the memory holds.
    always_comb
    begin
        res.count_eff  = ent_assigned ? ent.count : 8'd0;
        res.tag_match  = ent_assigned && (ent.device == req_device) && (ent.block == req_block);
        res.count_zero = (res.count_eff == 8'd0);
        res.count_inc  = (res.count_eff == COUNT_MAX) ? res.count_eff : res.count_eff + 8'd1;
    end

endmodule

// ===== sv/block_buffer_cache_lookup.sv =====
// Buffer cache lookup and allocate: top level with the scan sequencer.
// A read runs a tag scan and, on a miss, a free-entry scan, each at one entry per
// cycle; a hit ends the tag scan early. Mark dirty and query read the addressed
// entry directly, and an index beyond the table goes straight to the result.
// One word is in work at a time; in_ready returns with the result, so a new word
// is accepted only once the result of the last one has entered the output register.
// Reset (rst_n, asynchronous, active low) empties the table at once.
`timescale 1ns / 1ps
`include "block_buffer_cache_lookup_assert.svh"
module block_buffer_cache_lookup
    import bbcl_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] device,
    input  logic [7:0] block_number,
    input  logic [3:0] entry_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] result_index,
    output logic       hit,
    output logic       needs_disk_read,
    output logic       status,
    output logic [7:0] reference_count
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // Sequencer state and the captured request word.
    state_t state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic [7:0] dev_reg, dev_next;
    logic [7:0] blk_reg, blk_next;

    // Scan address, and the index whose memory data is currently on rd_data.
    logic [IW-1:0] addr_reg, addr_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic          pv_reg, pv_next;

    // Per-entry marks live in flip-flops so that reset clears them at once. The
    // assigned mark also acts as the valid bit of the memory entry: an unassigned
    // entry never matches a tag and its count reads as zero.
    logic [ENTRIES-1:0] assigned_reg, assigned_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] dirty_reg, dirty_next;

    // Finished result waiting for the output register.
    logic [3:0] res_index_reg, res_index_next;
    logic       res_hit_reg, res_hit_next;
    logic       res_ndr_reg, res_ndr_next;
    logic       res_status_reg, res_status_next;
    logic [7:0] res_count_reg, res_count_next;

    // Output register.
    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_index_reg, out_index_next;
    logic       out_hit_reg, out_hit_next;
    logic       out_ndr_reg, out_ndr_next;
    logic       out_status_reg, out_status_next;
    logic [7:0] out_count_reg, out_count_next;

    // Memory ports.
    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;

    cmp_res_t cmp;

    logic          accept;
    logic          idx_ok;
    logic [IW-1:0] idx_ent;
    logic          hit_found, hscan_end, free_found, fscan_end, out_load;

    bbcl_table #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbcl_cmp u_cmp (
        .ent          (rd_data),
        .ent_assigned (assigned_reg[pidx_reg]),
        .req_device   (dev_reg),
        .req_block    (blk_reg),
        .res          (cmp)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // The addressed modes reject an index beyond the table.
    assign idx_ok  = (32'(entry_index) < ENTRIES);
    assign idx_ent = IW'(entry_index);

    // Scan decisions, each looking at the entry whose data came back this cycle.
    assign hit_found  = pv_reg && cmp.tag_match;
    assign hscan_end  = pv_reg && (pidx_reg == LAST);
    assign free_found = pv_reg && cmp.count_zero;
    assign fscan_end  = pv_reg && (pidx_reg == '0);
    assign out_load   = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_READ)
                    begin
                        state_next = ST_HSCAN;
                    end
                    else if (idx_ok)
                    begin
                        state_next = ST_DREAD;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_HSCAN:
            begin
                priority if (hit_found)
                begin
                    state_next = ST_WAIT;
                end
                else if (hscan_end)
                begin
                    state_next = ST_FSCAN;
                end
            end
            ST_FSCAN:
            begin
                if (free_found || fscan_end)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_DREAD:
            begin
                state_next = ST_DIRECT;
            end
            ST_DIRECT:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        mode_next       = mode_reg;
        dev_next        = dev_reg;
        blk_next        = blk_reg;
        addr_next       = addr_reg;
        pidx_next       = pidx_reg;
        pv_next         = 1'b0;
        assigned_next   = assigned_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        res_index_next  = res_index_reg;
        res_hit_next    = res_hit_reg;
        res_ndr_next    = res_ndr_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_index_next  = out_index_reg;
        out_hit_next    = out_hit_reg;
        out_ndr_next    = out_ndr_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = pidx_reg;
        wr_data         = '{device: dev_reg, block: blk_reg, count: cmp.count_inc};
        rd_en           = 1'b0;
        rd_addr         = addr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    dev_next  = device;
                    blk_next  = block_number;
                    addr_next = (mode == MODE_READ) ? '0 : idx_ent;
                    // Error result for an addressed mode outside the table.
                    res_index_next  = entry_index;
                    res_hit_next    = 1'b0;
                    res_ndr_next    = 1'b0;
                    res_status_next = STATUS_ERROR;
                    res_count_next  = 8'd0;
                end
            end
            ST_HSCAN:
            begin
                priority if (hit_found)
                begin
                    // Hit: bump the count, the entry ends valid and clean.
                    wr_en                = 1'b1;
                    valid_next[pidx_reg] = 1'b1;
                    dirty_next[pidx_reg] = 1'b0;
                    res_index_next       = 4'(pidx_reg);
                    res_hit_next         = 1'b1;
                    res_ndr_next         = !valid_reg[pidx_reg];
                    res_status_next      = STATUS_OK;
                    res_count_next       = cmp.count_inc;
                end
                else if (hscan_end)
                begin
                    // Miss: search for a free entry from the top down.
                    addr_next = LAST;
                end
                else
                begin
                    rd_en     = 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = addr_reg;
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_FSCAN:
            begin
                priority if (free_found)
                begin
                    // Retag the free entry with a count of one.
                    wr_en                   = 1'b1;
                    wr_data.count           = 8'd1;
                    assigned_next[pidx_reg] = 1'b1;
                    valid_next[pidx_reg]    = 1'b1;
                    dirty_next[pidx_reg]    = 1'b0;
                    res_index_next          = 4'(pidx_reg);
                    res_hit_next            = 1'b0;
                    res_ndr_next            = 1'b1;
                    res_status_next         = STATUS_OK;
                    res_count_next          = 8'd1;
                end
                else if (fscan_end)
                begin
                    // Every entry is referenced: report a full table.
                    res_index_next  = 4'd0;
                    res_hit_next    = 1'b0;
                    res_ndr_next    = 1'b0;
                    res_status_next = STATUS_ERROR;
                    res_count_next  = 8'd0;
                end
                else
                begin
                    rd_en     = 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = addr_reg;
                    addr_next = addr_reg - 1'b1;
                end
            end
            ST_DREAD:
            begin
                rd_en     = 1'b1;
                pidx_next = addr_reg;
            end
            ST_DIRECT:
            begin
                if (mode_reg == MODE_DIRTY)
                begin
                    dirty_next[pidx_reg] = 1'b1;
                end
                res_index_next  = 4'(pidx_reg);
                res_hit_next    = 1'b0;
                res_ndr_next    = 1'b0;
                res_status_next = STATUS_OK;
                res_count_next  = cmp.count_eff;
            end
            ST_WAIT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = res_index_reg;
                    out_hit_next    = res_hit_reg;
                    out_ndr_next    = res_ndr_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = res_count_reg;
                end
            end
            default:
            begin
                pv_next = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pv_reg        <= 1'b0;
            assigned_reg  <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            assigned_reg  <= assigned_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        dev_reg        <= dev_next;
        blk_reg        <= blk_next;
        addr_reg       <= addr_next;
        pidx_reg       <= pidx_next;
        res_index_reg  <= res_index_next;
        res_hit_reg    <= res_hit_next;
        res_ndr_reg    <= res_ndr_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        out_index_reg  <= out_index_next;
        out_hit_reg    <= out_hit_next;
        out_ndr_reg    <= out_ndr_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid       = out_valid_reg;
    assign result_index    = out_index_reg;
    assign hit             = out_hit_reg;
    assign needs_disk_read = out_ndr_reg;
    assign status          = out_status_reg;
    assign reference_count = out_count_reg;

    // An entry can only be valid once it has been assigned a tag.
    `BBCL_ASSERT(a_valid_assigned, (valid_reg & ~assigned_reg) == '0, "valid entry not assigned")
    // A hit leaves the entry valid and clean.
    `BBCL_ASSERT(a_hit_clean, (state_reg == ST_HSCAN && hit_found) |=> (valid_reg[$past(pidx_reg)] && !dirty_reg[$past(pidx_reg)]), "hit entry not valid and clean")
    // An error result carries no hit and no count.
    `BBCL_ASSERT_IMPL(a_err_fields, state_reg == ST_WAIT && res_status_reg == STATUS_ERROR, !res_hit_reg && !res_ndr_reg && res_count_reg == 8'd0, "error result with payload")
    // A result only appears out of the wait state.
    `BBCL_ASSERT_IMPL(a_out_from_wait, $rose(out_valid_reg), $past(state_reg) == ST_WAIT, "result raised outside wait state")

endmodule

// ===== bench/block_buffer_cache_lookup_tb.sv =====
// Self-checking testbench for the buffer cache lookup and allocate block.
`timescale 1ns / 1ps
module block_buffer_cache_lookup_tb;
    import bbcl_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int POOL_SIZE    = 24;
    localparam int TAIL_CYCLES  = 2 * ENTRIES + 8;
    localparam int LIMIT_CYCLES = 600000;
    localparam int MAX_REPORTS  = 10;

    // Mode three has no name in the package; the block treats it as a query.
    localparam logic [1:0] MODE_QUERY_ALIAS = 2'd3;

    typedef struct packed {
        logic [3:0] index;
        logic       hit;
        logic       disk_read;
        logic       status;
        logic [7:0] count;
    } lookup_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] mode;
    logic [7:0] device;
    logic [7:0] block_number;
    logic [3:0] entry_index;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] result_index;
    logic       hit;
    logic       needs_disk_read;
    logic       status;
    logic [7:0] reference_count;

    // Shadow copy of the buffer table, updated as each word is accepted.
    logic [7:0] shadow_dev      [ENTRIES];
    logic [7:0] shadow_blk      [ENTRIES];
    logic [7:0] shadow_count    [ENTRIES];
    logic       shadow_valid    [ENTRIES];
    logic       shadow_dirty    [ENTRIES];
    logic       shadow_assigned [ENTRIES];

    // Tags that the random traffic draws from; entry zero is the hot tag.
    logic [7:0] pool_dev [POOL_SIZE];
    logic [7:0] pool_blk [POOL_SIZE];

    lookup_result_t expected_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    int error_count;
    int words_sent;
    int hit_total;
    int saturated_hits;
    int alloc_total;
    int full_misses;

    block_buffer_cache_lookup #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .device         (device),
        .block_number   (block_number),
        .entry_index    (entry_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_index   (result_index),
        .hit            (hit),
        .needs_disk_read(needs_disk_read),
        .status         (status),
        .reference_count(reference_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Works out the result of one accepted word and advances the shadow table.
    // A read hit takes the lowest matching assigned entry; a miss takes the
    // highest entry whose count is zero; with none left the table is full.
    function automatic void cache_predict(input logic [1:0] req_mode,
                                          input logic [7:0] req_dev,
                                          input logic [7:0] req_blk,
                                          input logic [3:0] req_idx);
        lookup_result_t r;
        int e;
        bit done;
        r = '0;
        r.status = STATUS_OK;
        done = 1'b0;
        if (req_mode == MODE_READ)
        begin
            for (e = 0; e < ENTRIES && !done; e++)
            begin
                if (shadow_assigned[e] && shadow_dev[e] == req_dev
                    && shadow_blk[e] == req_blk)
                begin
                    r.index = 4'(e);
                    r.hit = 1'b1;
                    r.disk_read = !shadow_valid[e];
                    if (shadow_count[e] == COUNT_MAX)
                        saturated_hits++;
                    else
                        shadow_count[e] = shadow_count[e] + 8'd1;
                    shadow_valid[e] = 1'b1;
                    shadow_dirty[e] = 1'b0;
                    r.count = shadow_count[e];
                    hit_total++;
                    done = 1'b1;
                end
            end
            for (e = ENTRIES - 1; e >= 0 && !done; e--)
            begin
                if (shadow_count[e] == 8'd0)
                begin
                    shadow_dev[e] = req_dev;
                    shadow_blk[e] = req_blk;
                    shadow_assigned[e] = 1'b1;
                    shadow_count[e] = 8'd1;
                    shadow_valid[e] = 1'b1;
                    shadow_dirty[e] = 1'b0;
                    r.index = 4'(e);
                    r.disk_read = 1'b1;
                    r.count = 8'd1;
                    alloc_total++;
                    done = 1'b1;
                end
            end
            if (!done)
            begin
                r.status = STATUS_ERROR;
                full_misses++;
            end
        end
        else if (int'(req_idx) >= ENTRIES)
        begin
            r.index = req_idx;
            r.status = STATUS_ERROR;
        end
        else
        begin
            // Mark dirty and query act on the entry whether it is assigned or not.
            if (req_mode == MODE_DIRTY)
                shadow_dirty[req_idx] = 1'b1;
            r.index = req_idx;
            r.count = shadow_count[req_idx];
        end
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input lookup_result_t exp_r,
                                   input lookup_result_t act_r);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%s at cycle %0d: expected idx=%0d hit=%0d ndr=%0d st=%0d cnt=%0d,",
                     what, cycle_count, exp_r.index, exp_r.hit, exp_r.disk_read,
                     exp_r.status, exp_r.count);
            $display("    got idx=%0d hit=%0d ndr=%0d st=%0d cnt=%0d",
                     act_r.index, act_r.hit, act_r.disk_read, act_r.status, act_r.count);
        end
    endtask

    // Result side: compare each accepted result with the oldest expectation,
    // then pick the ready level for the next cycle.
    always @(posedge clk)
    begin
        lookup_result_t act_r;
        lookup_result_t exp_r;
        act_r = {result_index, hit, needs_disk_read, status, reference_count};
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", '0, act_r);
            else
            begin
                exp_r = expected_results.pop_front();
                if (act_r !== exp_r)
                    report_mismatch("result mismatch", exp_r, act_r);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Sends one word. Valid is lowered only when an idle gap follows, so that
    // back-to-back words keep it high without a same-step drop.
    task automatic send_word(input logic [1:0] m, input logic [7:0] d,
                             input logic [7:0] b, input logic [3:0] ix);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        device       <= d;
        block_number <= b;
        entry_index  <= ix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cache_predict(m, d, b, ix);
        words_sent++;
    endtask

    // Idles the input and waits until every result is in, plus the block's latency.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Allocation from the top of the table, hits, and the addressed modes on
    // both assigned and unassigned entries.
    task automatic test_allocate_and_hit();
        pool_dev[0] = 8'h00; pool_blk[0] = 8'h00;
        pool_dev[1] = 8'hFF; pool_blk[1] = 8'hFF;
        pool_dev[2] = 8'h00; pool_blk[2] = 8'hFF;
        pool_dev[3] = 8'hFF; pool_blk[3] = 8'h00;
        send_word(MODE_READ, pool_dev[0], pool_blk[0], 4'd0);
        send_word(MODE_READ, pool_dev[0], pool_blk[0], 4'd15);
        send_word(MODE_READ, pool_dev[1], pool_blk[1], 4'd0);
        send_word(MODE_QUERY, 8'hFF, 8'hFF, 4'd15);
        send_word(MODE_QUERY, 8'h00, 8'h00, 4'd0);
        send_word(MODE_DIRTY, 8'hFF, 8'h00, 4'd0);
        send_word(MODE_DIRTY, 8'h00, 8'hFF, 4'd15);
        // A hit on a dirty entry leaves it clean again.
        send_word(MODE_READ, pool_dev[0], pool_blk[0], 4'd0);
        send_word(MODE_QUERY_ALIAS, 8'h5A, 8'hA5, 4'd14);
        send_word(MODE_READ, pool_dev[2], pool_blk[2], 4'd0);
        send_word(MODE_READ, pool_dev[3], pool_blk[3], 4'd0);
    endtask

    // Fills the rest of the table, then a fresh tag finds no free entry and a known tag still hits.
    task automatic test_table_full();
        int k;
        for (k = 0; k < 12; k++)
        begin
            pool_dev[4 + k] = 8'h10 + 8'(k);
            pool_blk[4 + k] = 8'hA5 ^ 8'(k);
            send_word(MODE_READ, pool_dev[4 + k], pool_blk[4 + k], 4'(k));
        end
        for (k = 0; k < 8; k++)
        begin
            pool_dev[16 + k] = 8'h80 + 8'(k);
            pool_blk[16 + k] = 8'h01 + 8'(k);
        end
        send_word(MODE_READ, pool_dev[16], pool_blk[16], 4'd0);
        send_word(MODE_READ, pool_dev[15], pool_blk[15], 4'd0);
    endtask

    // Mostly reads of known tags, heavy on the hot tag so its count saturates,
    // mixed with addressed words and some reads of arbitrary tags.
    task automatic test_random_traffic(input int count);
        int n;
        int pick;
        int slot;
        logic [7:0] d;
        logic [7:0] b;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            d = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            if (pick < 55)
            begin
                slot = $urandom_range(0, 99);
                if (slot < 45)
                begin
                    d = pool_dev[0];
                    b = pool_blk[0];
                end
                else if (slot < 85)
                begin
                    slot = $urandom_range(0, POOL_SIZE - 1);
                    d = pool_dev[slot];
                    b = pool_blk[slot];
                end
                send_word(MODE_READ, d, b, 4'($urandom_range(0, 15)));
            end
            else if (pick < 75)
                send_word(MODE_DIRTY, d, b, 4'($urandom_range(0, 15)));
            else if (pick < 90)
                send_word(MODE_QUERY, d, b, 4'($urandom_range(0, 15)));
            else
                send_word(MODE_QUERY_ALIAS, d, b, 4'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_READ;
        device         = 8'd0;
        block_number   = 8'd0;
        entry_index    = 4'd0;
        out_ready      = 1'b0;
        cycle_count    = 0;
        error_count    = 0;
        words_sent     = 0;
        hit_total      = 0;
        saturated_hits = 0;
        alloc_total    = 0;
        full_misses    = 0;
        send_idle_pct  = 12;
        recv_idle_pct  = 86;
        for (int e = 0; e < ENTRIES; e++)
        begin
            shadow_dev[e]      = 8'd0;
            shadow_blk[e]      = 8'd0;
            shadow_count[e]    = 8'd0;
            shadow_valid[e]    = 1'b0;
            shadow_dirty[e]    = 1'b0;
            shadow_assigned[e] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_allocate_and_hit();
        test_table_full();
        test_random_traffic(360);
        drain();

        send_idle_pct = 86;
        recv_idle_pct = 12;
        test_random_traffic(360);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(360);
        drain();

        $display("tb: %0d words: %0d hits (%0d at a saturated count), %0d allocations,",
                 words_sent, hit_total, saturated_hits, alloc_total);
        $display("tb: %0d misses on a full table, %0d mismatches over %0d cycles",
                 full_misses, error_count, cycle_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
